[hdl/tkd_pkg.sv]
package tkd_pkg;

	localparam int MAX_DIM   = 1024;
	localparam int DIM_LIMIT = (MAX_DIM < 1024) ? MAX_DIM : 1024;

	localparam logic [7:0] BYTE_ESC     = 8'h1b;
	localparam logic [7:0] BYTE_TILDE   = 8'h7e;
	localparam logic [7:0] BYTE_BRACKET = 8'h5b;
	localparam logic [7:0] BYTE_OH      = 8'h4f;
	localparam logic [7:0] CTRL_MASK    = 8'h1f;

	localparam logic [8:0] KEY_ESC    = 9'd27;
	localparam logic [8:0] KEY_CTRL_Q = {1'b0, 8'h71 & CTRL_MASK};
	localparam logic [8:0] KEY_LEFT   = 9'd256;
	localparam logic [8:0] KEY_RIGHT  = 9'd257;
	localparam logic [8:0] KEY_UP     = 9'd258;
	localparam logic [8:0] KEY_DOWN   = 9'd259;
	localparam logic [8:0] KEY_INSERT = 9'd260;
	localparam logic [8:0] KEY_DELETE = 9'd261;
	localparam logic [8:0] KEY_HOME   = 9'd262;
	localparam logic [8:0] KEY_END    = 9'd263;
	localparam logic [8:0] KEY_PGUP   = 9'd264;
	localparam logic [8:0] KEY_PGDN   = 9'd265;

	localparam logic REG_COLS = 1'b0;
	localparam logic REG_ROWS = 1'b1;

	localparam logic [9:0] LAST_COL_RST = 10'd79;
	localparam logic [9:0] LAST_ROW_RST = 10'd23;
	localparam logic [9:0] POS_RST      = 10'd10;

	typedef struct packed {
		logic       have;
		logic [8:0] code;
	} key_t;

	function automatic logic [9:0] last_of(input logic [10:0] v);
		logic [9:0] r;
		if (v == 11'd0) begin
			r = 10'd0;
		end else if (v > 11'(DIM_LIMIT)) begin
			r = 10'(DIM_LIMIT - 1);
		end else begin
			r = 10'(v - 11'd1);
		end
		return r;
	endfunction

	function automatic logic [8:0] tilde_key(input logic [3:0] d);
		logic [8:0] k;
		case (d)
			4'd1:    k = KEY_HOME;
			4'd2:    k = KEY_INSERT;
			4'd3:    k = KEY_DELETE;
			4'd4:    k = KEY_END;
			4'd5:    k = KEY_PGUP;
			4'd6:    k = KEY_PGDN;
			4'd7:    k = KEY_HOME;
			4'd8:    k = KEY_END;
			default: k = KEY_ESC;
		endcase
		return k;
	endfunction

	function automatic logic [8:0] letter_key(input logic [7:0] b);
		logic [8:0] k;
		case (b)
			8'h41:   k = KEY_UP;
			8'h42:   k = KEY_DOWN;
			8'h43:   k = KEY_RIGHT;
			8'h44:   k = KEY_LEFT;
			8'h48:   k = KEY_HOME;
			8'h46:   k = KEY_END;
			default: k = KEY_ESC;
		endcase
		return k;
	endfunction

endpackage

[hdl/tkd_parser.sv]
module tkd_parser (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          fire,
	input  logic          op,
	input  logic [7:0]    data_byte,
	output tkd_pkg::key_t key
);
	import tkd_pkg::*;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_ESC,
		PH_BRACKET,
		PH_OH,
		PH_SKIP,
		PH_DIGIT
	} phase_t;

	phase_t     phase_q, phase_d;
	logic [3:0] digit_q, digit_d;
	logic       is_digit;

	assign is_digit = (data_byte >= 8'h30) && (data_byte <= 8'h39);

	always_comb begin
		phase_d  = phase_q;
		digit_d  = digit_q;
		key.have = 1'b0;
		key.code = KEY_ESC;
		if (op) begin
			if (phase_q != PH_IDLE) begin
				key.have = 1'b1;
				phase_d  = PH_IDLE;
			end
		end else begin
			case (phase_q)
				PH_IDLE: begin
					if (data_byte == BYTE_ESC) begin
						phase_d = PH_ESC;
					end else begin
						key.have = 1'b1;
						key.code = {1'b0, data_byte};
					end
				end
				PH_ESC: begin
					if (data_byte == BYTE_BRACKET) begin
						phase_d = PH_BRACKET;
					end else if (data_byte == BYTE_OH) begin
						phase_d = PH_OH;
					end else begin
						phase_d = PH_SKIP;
					end
				end
				PH_BRACKET: begin
					if (is_digit) begin
						digit_d = data_byte[3:0];
						phase_d = PH_DIGIT;
					end else begin
						key.have = 1'b1;
						key.code = letter_key(data_byte);
						phase_d  = PH_IDLE;
					end
				end
				PH_OH: begin
					key.have = 1'b1;
					if (data_byte == 8'h48) begin
						key.code = KEY_HOME;
					end else if (data_byte == 8'h46) begin
						key.code = KEY_END;
					end
					phase_d = PH_IDLE;
				end
				PH_DIGIT: begin
					key.have = 1'b1;
					if (data_byte == BYTE_TILDE) begin
						key.code = tilde_key(digit_q);
					end
					phase_d = PH_IDLE;
				end
				default: begin
					key.have = 1'b1;
					phase_d  = PH_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			digit_q <= 4'd0;
		end else if (fire) begin
			phase_q <= phase_d;
			digit_q <= digit_d;
		end
	end

endmodule

[hdl/tkd_cursor.sv]
module tkd_cursor (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic          cfg_index,
	input  logic [10:0]   cfg_data,
	input  logic          fire,
	input  tkd_pkg::key_t key,
	output logic [9:0]    col_next,
	output logic [9:0]    row_next
);
	import tkd_pkg::*;

	logic [9:0] last_col_q, last_row_q;
	logic [9:0] col_q, row_q;

	always_comb begin
		col_next = col_q;
		row_next = row_q;
		case (key.code)
			KEY_LEFT: begin
				if (col_q != 10'd0) begin
					col_next = col_q - 10'd1;
				end
			end
			KEY_RIGHT: begin
				col_next = (col_q >= last_col_q) ? last_col_q : col_q + 10'd1;
			end
			KEY_UP: begin
				if (row_q != 10'd0) begin
					row_next = row_q - 10'd1;
				end
			end
			KEY_DOWN: begin
				row_next = (row_q >= last_row_q) ? last_row_q : row_q + 10'd1;
			end
			KEY_HOME: col_next = 10'd0;
			KEY_END:  col_next = last_col_q;
			KEY_PGUP: row_next = 10'd0;
			KEY_PGDN: row_next = last_row_q;
			default:  ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_col_q <= LAST_COL_RST;
			last_row_q <= LAST_ROW_RST;
		end else if (cfg_we) begin
			if (cfg_index == REG_COLS) begin
				last_col_q <= last_of(cfg_data);
			end
			if (cfg_index == REG_ROWS) begin
				last_row_q <= last_of(cfg_data);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= POS_RST;
			row_q <= POS_RST;
		end else if (fire && key.have) begin
			col_q <= col_next;
			row_q <= row_next;
		end
	end

endmodule

[hdl/terminal_key_decoder_cursor.sv]
// terminal key decoder with cursor tracking
// input stream: s_tdata carries one terminal byte, s_tuser flags a read
// timeout (byte ignored). output stream: one transfer per completed key,
// with the key code, cursor column and row in m_tdata and the ctrl-q quit
// flag in m_tuser. a timeout while idle and the leading bytes of an escape
// sequence produce no output transfer.
// cfg_we/cfg_index/cfg_data set the screen size (index 0 columns, index 1
// rows); write only while no transfer is in flight.
// a key is held in the input register and then passes through the
// combinational decode and cursor logic into the output register, which
// holds its output transfer.
// throughput: one input transfer per cycle while m_tready is high, set by
// the combinational decode/cursor update between the two registers.
// if the receiver holds m_tready low, the output register keeps its
// transfer, one more input item waits in the input register, and then
// s_tready drops until the output drains.
// reset: parser idle, screen 80x24, cursor at column 10 row 10, both
// streams empty.
module terminal_key_decoder_cursor (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // data_byte
	input  logic        s_tuser,   // op
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // key_code[8:0], cursor_col[18:9], cursor_row[28:19]
	output logic        m_tuser,   // quit
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [10:0] cfg_data
);
	import tkd_pkg::*;

	logic       valid_s1;
	logic       op_s1;
	logic [7:0] byte_s1;
	logic       proc;
	key_t       key;
	logic [9:0] col_next, row_next;

	logic       valid_s2;
	logic [8:0] key_s2;
	logic       quit_s2;
	logic [9:0] col_s2, row_s2;

	assign proc     = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || proc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (proc) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_s1   <= s_tuser;
			byte_s1 <= s_tdata;
		end
	end

	tkd_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (proc),
		.op        (op_s1),
		.data_byte (byte_s1),
		.key       (key)
	);

	tkd_cursor u_cursor (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.fire      (proc),
		.key       (key),
		.col_next  (col_next),
		.row_next  (row_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (proc && key.have) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (proc && key.have) begin
			key_s2  <= key.code;
			quit_s2 <= (key.code == KEY_CTRL_Q);
			col_s2  <= col_next;
			row_s2  <= row_next;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {3'b000, row_s2, col_s2, key_s2};
	assign m_tuser  = quit_s2;

`ifndef SYNTHESIS
	a_ready_low_needs_held_item: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> valid_s1)
		else $error("input stalled with empty input register");

	a_quit_matches_key: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata[8:0] == KEY_CTRL_Q)
		else $error("quit flag on a key other than ctrl-q");

	a_key_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[8:0] <= KEY_PGDN)
		else $error("key code out of range");

	a_held_item_kept: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !proc |=> valid_s1 && $stable(byte_s1) && $stable(op_s1))
		else $error("input register lost an unprocessed item");

	a_stall_blocks_processing: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !m_tready |-> !proc)
		else $error("processing while output register is stalled");
`endif

endmodule

[test/terminal_key_decoder_cursor_tb.sv]
`timescale 1ns / 1ps

module terminal_key_decoder_cursor_tb;
	import tkd_pkg::*;

	localparam int HALF_PERIOD  = 4;
	localparam int RESET_CYCLES = 12;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int DRAIN_CYCLES = 6;

	typedef enum logic [2:0] {
		P_IDLE,
		P_ESC,
		P_BRACKET,
		P_OH,
		P_SKIP,
		P_DIGIT
	} seq_phase_e;

	typedef struct packed {
		logic [8:0] code;
		logic       quit;
		logic [9:0] col;
		logic [9:0] row;
	} key_result_t;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata   = 8'h00;
	logic        s_tuser   = 1'b0;
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [31:0] m_tdata;
	logic        m_tuser;
	logic        cfg_we    = 1'b0;
	logic        cfg_index = REG_COLS;
	logic [10:0] cfg_data  = 11'd0;

	seq_phase_e  seq_phase = P_IDLE;
	logic [7:0]  digit_byte = 8'h00;
	logic [9:0]  cur_col = POS_RST;
	logic [9:0]  cur_row = POS_RST;
	logic [10:0] cols_reg = 11'd80;
	logic [10:0] rows_reg = 11'd24;
	key_result_t pending_keys[$];

	int gap_max    = 4;
	int stall_max  = 4;
	int stall_left = 0;
	int n_sent     = 0;
	int n_keys     = 0;
	int n_cfg      = 0;
	int n_errors   = 0;
	int cycles     = 0;

	terminal_key_decoder_cursor u_dut (.*);

	always #HALF_PERIOD clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d keys outstanding", cycles,
				pending_keys.size());
			$display("** terminal_key_decoder_cursor: FAILED **");
			$finish;
		end
	end

	task automatic report_error(input string msg);
		$display("mismatch at %0t: %s", $time, msg);
		n_errors++;
	endtask

	function automatic logic [9:0] last_index(input logic [10:0] size);
		if (size == 11'd0)
			return 10'd0;
		if (size > 11'(DIM_LIMIT))
			return 10'(DIM_LIMIT - 1);
		return 10'(size - 11'd1);
	endfunction

	task automatic predict_key(input logic op, input logic [7:0] b);
		logic [8:0]  code;
		logic        produce;
		logic [9:0]  last_col;
		logic [9:0]  last_row;
		key_result_t res;
		code = 9'd0;
		produce = 1'b0;
		if (op) begin
			if (seq_phase != P_IDLE) begin
				code = KEY_ESC;
				produce = 1'b1;
				seq_phase = P_IDLE;
			end
		end else begin
			case (seq_phase)
				P_IDLE: begin
					if (b == BYTE_ESC) begin
						seq_phase = P_ESC;
					end else begin
						code = {1'b0, b};
						produce = 1'b1;
					end
				end
				P_ESC: begin
					if (b == BYTE_BRACKET)
						seq_phase = P_BRACKET;
					else if (b == BYTE_OH)
						seq_phase = P_OH;
					else
						seq_phase = P_SKIP;
				end
				P_BRACKET: begin
					if (b >= "0" && b <= "9") begin
						digit_byte = b;
						seq_phase = P_DIGIT;
					end else begin
						case (b)
							"A":     code = KEY_UP;
							"B":     code = KEY_DOWN;
							"C":     code = KEY_RIGHT;
							"D":     code = KEY_LEFT;
							"H":     code = KEY_HOME;
							"F":     code = KEY_END;
							default: code = KEY_ESC;
						endcase
						produce = 1'b1;
						seq_phase = P_IDLE;
					end
				end
				P_OH: begin
					if (b == "H")
						code = KEY_HOME;
					else if (b == "F")
						code = KEY_END;
					else
						code = KEY_ESC;
					produce = 1'b1;
					seq_phase = P_IDLE;
				end
				P_DIGIT: begin
					code = KEY_ESC;
					if (b == BYTE_TILDE) begin
						case (digit_byte)
							"1", "7": code = KEY_HOME;
							"2":      code = KEY_INSERT;
							"3":      code = KEY_DELETE;
							"4", "8": code = KEY_END;
							"5":      code = KEY_PGUP;
							"6":      code = KEY_PGDN;
							default:  code = KEY_ESC;
						endcase
					end
					produce = 1'b1;
					seq_phase = P_IDLE;
				end
				default: begin
					code = KEY_ESC;
					produce = 1'b1;
					seq_phase = P_IDLE;
				end
			endcase
		end
		if (produce) begin
			last_col = last_index(cols_reg);
			last_row = last_index(rows_reg);
			case (code)
				KEY_LEFT:  if (cur_col != 10'd0) cur_col = cur_col - 10'd1;
				KEY_RIGHT: cur_col = (cur_col >= last_col) ? last_col : cur_col + 10'd1;
				KEY_UP:    if (cur_row != 10'd0) cur_row = cur_row - 10'd1;
				KEY_DOWN:  cur_row = (cur_row >= last_row) ? last_row : cur_row + 10'd1;
				KEY_HOME:  cur_col = 10'd0;
				KEY_END:   cur_col = last_col;
				KEY_PGUP:  cur_row = 10'd0;
				KEY_PGDN:  cur_row = last_row;
				default: begin
				end
			endcase
			res.code = code;
			res.quit = (code == KEY_CTRL_Q);
			res.col  = cur_col;
			res.row  = cur_row;
			pending_keys.push_back(res);
		end
	endtask

	always @(negedge clk) begin
		if (stall_left > 0) begin
			m_tready <= 1'b0;
			stall_left <= stall_left - 1;
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin : check_key
		key_result_t got;
		key_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.code = m_tdata[8:0];
			got.quit = m_tuser;
			got.col  = m_tdata[18:9];
			got.row  = m_tdata[28:19];
			stall_left <= $urandom_range(0, stall_max);
			n_keys++;
			if (pending_keys.size() == 0) begin
				report_error($sformatf("unexpected key transfer, key_code %0d", got.code));
			end else begin
				want = pending_keys.pop_front();
				if (got.code !== want.code)
					report_error($sformatf("key_code got %0d expected %0d",
						got.code, want.code));
				if (got.quit !== want.quit)
					report_error($sformatf("quit got %0b expected %0b",
						got.quit, want.quit));
				if (got.col !== want.col)
					report_error($sformatf("cursor_col got %0d expected %0d",
						got.col, want.col));
				if (got.row !== want.row)
					report_error($sformatf("cursor_row got %0d expected %0d",
						got.row, want.row));
			end
		end
	end

	task automatic send_byte(input logic op, input logic [7:0] b);
		int gap;
		gap = $urandom_range(0, gap_max);
		repeat (gap) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= b;
		do @(posedge clk); while (!s_tready);
		predict_key(op, b);
		n_sent++;
		@(negedge clk);
	endtask

	task automatic send_rx(input logic [7:0] b);
		send_byte(1'b0, b);
	endtask

	task automatic send_timeout();
		send_byte(1'b1, 8'($urandom));
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (pending_keys.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_size(input logic idx, input logic [10:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_COLS)
			cols_reg = value;
		else
			rows_reg = value;
		n_cfg++;
	endtask

	task automatic send_random_key();
		logic [7:0] tail;
		case ($urandom_range(0, 11))
			0, 1, 2: send_rx(8'($urandom));
			3, 4, 5: begin
				case ($urandom_range(0, 7))
					0, 1:    tail = "A";
					2:       tail = "B";
					3:       tail = "C";
					4:       tail = "D";
					5:       tail = "H";
					6:       tail = "F";
					default: tail = 8'($urandom);
				endcase
				send_rx(BYTE_ESC);
				send_rx(BYTE_BRACKET);
				send_rx(tail);
			end
			6, 7: begin
				send_rx(BYTE_ESC);
				send_rx(BYTE_BRACKET);
				send_rx(8'("0" + $urandom_range(0, 9)));
				send_rx(($urandom_range(0, 7) != 0) ? BYTE_TILDE : 8'($urandom));
			end
			8: begin
				case ($urandom_range(0, 2))
					0:       tail = "H";
					1:       tail = "F";
					default: tail = 8'($urandom);
				endcase
				send_rx(BYTE_ESC);
				send_rx(BYTE_OH);
				send_rx(tail);
			end
			9: begin
				send_rx(BYTE_ESC);
				send_rx(8'($urandom));
				send_rx(8'($urandom));
			end
			10: begin
				// sequence cut short by a timeout
				send_rx(BYTE_ESC);
				case ($urandom_range(0, 3))
					0: send_rx(BYTE_BRACKET);
					1: send_rx(BYTE_OH);
					2: begin
						send_rx(BYTE_BRACKET);
						send_rx(8'("0" + $urandom_range(0, 9)));
					end
					default: send_rx(8'($urandom));
				endcase
				send_timeout();
			end
			default: begin
				if ($urandom_range(0, 1))
					send_rx(KEY_CTRL_Q[7:0]);
				else
					send_timeout();
			end
		endcase
	endtask

	task automatic send_random_items(input int count);
		int stop_at;
		stop_at = n_sent + count;
		while (n_sent < stop_at)
			send_random_key();
	endtask

	task automatic test_plain_bytes();
		gap_max = 4;
		stall_max = 4;
		send_rx(8'h00);
		send_rx(8'hff);
		send_rx(KEY_CTRL_Q[7:0]);
		send_rx(8'h7f);
		send_timeout();
	endtask

	task automatic test_escape_sequences();
		send_rx(BYTE_ESC);
		send_rx(BYTE_BRACKET);
		send_rx("A");
		send_rx(BYTE_ESC);
		send_rx(BYTE_BRACKET);
		send_rx("D");
		send_rx(BYTE_ESC);
		send_rx(BYTE_OH);
		send_rx("H");
		send_rx(BYTE_ESC);
		send_rx(BYTE_BRACKET);
		send_rx("6");
		send_rx(BYTE_TILDE);
		send_rx(BYTE_ESC);
		send_rx(BYTE_BRACKET);
		send_rx("9");
		send_rx(BYTE_TILDE);
		send_rx(BYTE_ESC);
		send_rx(8'hff);
		send_rx(8'h00);
		send_rx(BYTE_ESC);
		send_timeout();
	endtask

	task automatic test_back_to_back();
		gap_max = 0;
		stall_max = 0;
		send_random_items(80);
		wait_drained();
	endtask

	task automatic test_screen_sizes();
		logic [10:0] col_sizes[7] = '{11'd1024, 11'd5, 11'd2047, 11'd0, 11'd1, 11'd1025, 11'd80};
		logic [10:0] row_sizes[7] = '{11'd1024, 11'd3, 11'd2047, 11'd0, 11'd1, 11'd1000, 11'd24};
		for (int i = 0; i < 7; i++) begin
			wait_drained();
			write_size(REG_COLS, col_sizes[i]);
			write_size(REG_ROWS, row_sizes[i]);
			gap_max = (i % 3 == 1) ? 0 : 4;
			stall_max = (i % 3 == 2) ? 0 : 4;
			if (i == 0) begin
				// park the cursor far out so the next shrink leaves it off screen
				send_rx(BYTE_ESC);
				send_rx(BYTE_BRACKET);
				send_rx("F");
				send_rx(BYTE_ESC);
				send_rx(BYTE_BRACKET);
				send_rx("6");
				send_rx(BYTE_TILDE);
			end
			send_random_items(60);
		end
	endtask

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_plain_bytes();
		test_escape_sequences();
		wait_drained();
		test_back_to_back();
		test_screen_sizes();
		wait_drained();

		$display("run covered %0d input transfers, %0d key transfers, %0d size writes",
			n_sent, n_keys, n_cfg);
		if (n_errors == 0) begin
			$display("** terminal_key_decoder_cursor: PASSED **");
		end else begin
			$display("%0d mismatches", n_errors);
			$display("** terminal_key_decoder_cursor: FAILED **");
		end
		$finish;
	end

endmodule
